// ===== rtl/core/sspp_pkg.sv =====
// ----------------------------------------------------------------------------
// sspp_pkg
// shared types, codes and the coil phase table of the tray positioner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sspp_pkg;

    // tray geometry default
    localparam int STEPS_PER_REV = 200;

    // field widths
    localparam int KIND_W  = 2;
    localparam int POS_W   = 8;
    localparam int DELAY_W = 6;
    localparam int DIST_W  = 7;
    localparam int COIL_W  = 6;
    localparam int PHASE_W = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_DISTANCE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JOG_DELAY      = 3'd5;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_SEEK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_JOG  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;

    // register reset values
    localparam logic [DELAY_W-1:0] RST_MIN_DELAY      = 6'd6;
    localparam logic [DELAY_W-1:0] RST_MAX_DELAY      = 6'd20;
    localparam logic [DELAY_W-1:0] RST_START_DELAY    = 6'd16;
    localparam logic [DIST_W-1:0]  RST_ACCEL_DISTANCE = 7'd3;
    localparam logic [DIST_W-1:0]  RST_BRAKE_DISTANCE = 7'd10;
    localparam logic [DELAY_W-1:0] RST_JOG_DELAY      = 6'd20;
    localparam logic [DELAY_W-1:0] RST_DELAY          = 6'd16;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [DELAY_W-1:0] min_delay;
        logic [DELAY_W-1:0] max_delay;
        logic [DELAY_W-1:0] start_delay;
        logic [DIST_W-1:0]  accel_distance;
        logic [DIST_W-1:0]  brake_distance;
        logic [DELAY_W-1:0] jog_delay;
    } t_cfg;

    // one input item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  target_position;
        logic              jog_reverse;
        logic [POS_W-1:0]  new_position;
    } t_item;

    // one result item
    typedef struct packed {
        logic [COIL_W-1:0]  coil_pattern;
        logic [DELAY_W-1:0] step_delay_ms;
        logic [POS_W-1:0]   tray_position;
        logic               stepped;
        logic               at_target;
    } t_result;

    // coil drive pattern for each phase
    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] pat;
        case (ph)
            2'd0:    pat = 6'h36;
            2'd1:    pat = 6'h2E;
            2'd2:    pat = 6'h2D;
            2'd3:    pat = 6'h35;
            default: pat = 6'h36;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sspp_cfg.sv =====
// ----------------------------------------------------------------------------
// sspp_cfg
// configuration register file, one write transaction per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sspp_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic [sspp_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [sspp_pkg::CFG_DATA_W-1:0] i_data,
    output sspp_pkg::t_cfg                       o_cfg
);

    sspp_pkg::t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_delay      <= sspp_pkg::RST_MIN_DELAY;
            r_cfg.max_delay      <= sspp_pkg::RST_MAX_DELAY;
            r_cfg.start_delay    <= sspp_pkg::RST_START_DELAY;
            r_cfg.accel_distance <= sspp_pkg::RST_ACCEL_DISTANCE;
            r_cfg.brake_distance <= sspp_pkg::RST_BRAKE_DISTANCE;
            r_cfg.jog_delay      <= sspp_pkg::RST_JOG_DELAY;
        end else if (i_wr) begin
            case (i_index)
                sspp_pkg::REG_MIN_DELAY:      r_cfg.min_delay      <= i_data[5:0];
                sspp_pkg::REG_MAX_DELAY:      r_cfg.max_delay      <= i_data[5:0];
                sspp_pkg::REG_START_DELAY:    r_cfg.start_delay    <= i_data[5:0];
                sspp_pkg::REG_ACCEL_DISTANCE: r_cfg.accel_distance <= i_data;
                sspp_pkg::REG_BRAKE_DISTANCE: r_cfg.brake_distance <= i_data;
                sspp_pkg::REG_JOG_DELAY:      r_cfg.jog_delay      <= i_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/sspp_step.sv =====
// ----------------------------------------------------------------------------
// sspp_step
// motion state and the single-pass seek, jog and set update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sspp_step #(
    parameter int STEPS_PER_REV = sspp_pkg::STEPS_PER_REV
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire sspp_pkg::t_item   i_item,
    input  wire sspp_pkg::t_cfg    i_cfg,
    output sspp_pkg::t_result o_result
);

    localparam int POS_W   = sspp_pkg::POS_W;
    localparam int DELAY_W = sspp_pkg::DELAY_W;
    localparam int PHASE_W = sspp_pkg::PHASE_W;
    localparam int D_W     = POS_W + 2;

    localparam logic [POS_W-1:0]      REV_POS = POS_W'(STEPS_PER_REV);
    localparam logic signed [D_W-1:0] REV_D   = D_W'(STEPS_PER_REV);
    localparam logic signed [D_W-1:0] HALF_D  = D_W'(STEPS_PER_REV / 2);

    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [DELAY_W-1:0] r_delay,  n_delay;
    logic               r_accel,  n_accel;

    logic signed [D_W-1:0] w_d_raw, w_d_fold, w_d;
    logic        [D_W-1:0] w_mag;
    logic [DELAY_W-1:0]    w_dec;
    logic                  w_back;
    logic                  w_step;
    logic                  w_hit;
    logic [POS_W-1:0]      w_p;
    logic [POS_W-1:0]      w_p_step;
    logic [PHASE_W-1:0]    w_ph_step;

    // signed distance folded onto the shorter way round
    always_comb begin
        w_d_raw  = $signed({2'b00, i_item.target_position}) - $signed({2'b00, r_pos});
        w_d_fold = (w_d_raw >= HALF_D) ? (w_d_raw - REV_D) : w_d_raw;
        w_d      = (w_d_fold < -HALF_D) ? (w_d_fold + REV_D) : w_d_fold;
        w_mag    = w_d[D_W-1] ? D_W'(-w_d) : D_W'(w_d);
    end

    // delay ramp: shorten while far, then lengthen while near
    always_comb begin
        w_dec = r_delay;
        if (w_mag > D_W'(i_cfg.accel_distance) && r_delay > i_cfg.min_delay) begin
            w_dec = r_delay - DELAY_W'(1);
        end
    end

    // direction and whether a step is taken
    always_comb begin
        w_hit  = 1'b0;
        w_step = 1'b0;
        w_back = i_item.jog_reverse;
        case (i_item.kind)
            sspp_pkg::KIND_SEEK: begin
                w_hit  = (w_d == '0);
                w_step = (w_d != '0);
                w_back = w_d[D_W-1];
            end
            sspp_pkg::KIND_JOG: begin
                w_step = 1'b1;
            end
            default: ;
        endcase
    end

    // one step on the wrapping tray, slot zero aliases the full revolution
    always_comb begin
        w_p = (r_pos == '0) ? REV_POS : r_pos;
        if (w_back) begin
            w_ph_step = r_phase - PHASE_W'(1);
            w_p_step  = (w_p <= POS_W'(1)) ? REV_POS : (w_p - POS_W'(1));
        end else begin
            w_ph_step = r_phase + PHASE_W'(1);
            w_p_step  = (w_p >= REV_POS) ? POS_W'(1) : (w_p + POS_W'(1));
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_delay = r_delay;
        n_accel = r_accel;
        if (w_step) begin
            n_phase = w_ph_step;
            n_pos   = w_p_step;
        end
        case (i_item.kind)
            sspp_pkg::KIND_SEEK: begin
                if (w_step) begin
                    n_accel = 1'b1;
                    n_delay = w_dec;
                    if (w_mag < D_W'(i_cfg.brake_distance) && w_dec < i_cfg.max_delay) begin
                        n_delay = w_dec + DELAY_W'(1);
                    end
                end
            end
            sspp_pkg::KIND_SET: begin
                n_pos   = (i_item.new_position > REV_POS) ? REV_POS : i_item.new_position;
                n_delay = i_cfg.start_delay;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pos   <= '0;
            r_delay <= sspp_pkg::RST_DELAY;
            r_accel <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_delay <= n_delay;
            r_accel <= n_accel;
        end
    end

    // result from the state after this item
    always_comb begin
        o_result.coil_pattern  = sspp_pkg::coil_of(n_phase);
        o_result.step_delay_ms = n_accel ? n_delay : i_cfg.jog_delay;
        o_result.tray_position = n_pos;
        o_result.stepped       = w_step;
        o_result.at_target     = w_hit;
    end

endmodule

`default_nettype wire

// ===== rtl/core/stepper_shortest_path_positioner.sv =====
// ----------------------------------------------------------------------------
// stepper_shortest_path_positioner
// four-phase stepper positioner for a circular tray with a delay ramp
// ----------------------------------------------------------------------------
// Each input transaction (seek, jog or set, kind in tuser) is captured in an
// input register, updated against the motion state by combinational logic
// and presented from an output register; one result per item. The block
// takes a new item in every cycle while the output side keeps up; the update
// is registered into the output register only when that register is free or
// emptying, and the throughput of one item per cycle is set by the single
// state update of phase, position and delay.
// Configuration writes are accepted in every cycle and must only be issued
// while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module stepper_shortest_path_positioner #(
    parameter int STEPS_PER_REV = sspp_pkg::STEPS_PER_REV
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sspp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sspp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // item stream in
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: target_position[7:0], jog_reverse[8], new_position[16:9], zero pad
    input  wire logic [23:0]                     s_axis_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    // result stream out
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: coil_pattern[5:0], step_delay_ms[11:6], tray_position[19:12],
    //        stepped[20], at_target[21], zero pad
    output logic [23:0]                          m_axis_tdata
);

    sspp_pkg::t_cfg    w_cfg;
    sspp_pkg::t_item   r_item;
    sspp_pkg::t_result w_result;
    sspp_pkg::t_result r_result;

    logic r_in_valid;
    logic r_out_valid;
    logic w_in_acc;
    logic w_adv;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    sspp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // handshake: the item moves on when the output register is free or emptying
    assign w_adv         = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_adv;
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item.kind            <= s_axis_tuser;
            r_item.target_position <= s_axis_tdata[7:0];
            r_item.jog_reverse     <= s_axis_tdata[8];
            r_item.new_position    <= s_axis_tdata[16:9];
        end
    end

    // motion state and update
    sspp_step #(
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_result.at_target,
                            r_result.stepped,
                            r_result.tray_position,
                            r_result.step_delay_ms,
                            r_result.coil_pattern};

endmodule

`default_nettype wire
